>>> hw/rtl/dtmf_pkg.sv
// ----------------------------------------------------------------------------
// DTMF tone generator package
// Shared word formats, keypad codes and the constant tables for the phase
// increments and the quarter-wave sine.
// ----------------------------------------------------------------------------
package dtmf_pkg;

  // Numeric format of the synthesis.
  localparam int unsigned SampleRate    = 44100;
  localparam int unsigned PhaseBits     = 32;
  localparam int unsigned SineTableBits = 10;
  localparam int unsigned QuarterBits   = SineTableBits - 2;
  localparam int unsigned QuarterLen    = 1 << QuarterBits;
  localparam int unsigned ToneLenBits   = 16;
  localparam int unsigned SampleBits    = 16;
  localparam int unsigned TabValBits    = 15;

  // Output scaling: 32760 / 2 in Q15.
  localparam int unsigned MixGain       = 16380;
  localparam int unsigned MixGainBits   = 14;
  localparam int unsigned MixShift      = 15;

  localparam logic [ToneLenBits-1:0] ToneSamplesReset = ToneLenBits'(4410);

  // Item codes.
  typedef enum logic {
    OpLoad = 1'b0,
    OpTick = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] digit_code;
  } in_word_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample;
    logic                         tone_active;
    logic                         last_sample;
  } out_word_t;

  // Result of the keypad decode.
  typedef struct packed {
    logic       hit;
    logic [1:0] row;
    logic [1:0] col;
  } key_t;

  // Keypad characters.
  localparam logic [7:0] CharStar  = 8'h2A;
  localparam logic [7:0] CharHash  = 8'h23;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharOne   = 8'h31;
  localparam logic [7:0] CharTwo   = 8'h32;
  localparam logic [7:0] CharThree = 8'h33;
  localparam logic [7:0] CharFour  = 8'h34;
  localparam logic [7:0] CharFive  = 8'h35;
  localparam logic [7:0] CharSix   = 8'h36;
  localparam logic [7:0] CharSeven = 8'h37;
  localparam logic [7:0] CharEight = 8'h38;
  localparam logic [7:0] CharNine  = 8'h39;

  // Phase increment: round(f * 2^PhaseBits / SampleRate), ties up.
  function automatic logic [PhaseBits-1:0] step_for(input logic [63:0] freq);
    logic [63:0] num;
    num = (freq << PhaseBits) + 64'(SampleRate / 2);
    return PhaseBits'(num / SampleRate);
  endfunction

  localparam logic [PhaseBits-1:0] RowStep [4] = '{
    step_for(64'd697), step_for(64'd770), step_for(64'd852), step_for(64'd941)
  };
  localparam logic [PhaseBits-1:0] ColStep [3] = '{
    step_for(64'd1209), step_for(64'd1336), step_for(64'd1477)
  };

  // Quarter-wave sine, built at elaboration with an integer Taylor series
  // in Q30 and rounded half up to Q15.
  localparam int unsigned TaylorTerms = 12;
  localparam logic [63:0] HalfPiQ30   = 64'd1686629713;
  localparam logic [63:0] TaylorDiv [TaylorTerms] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  typedef logic [TabValBits-1:0] quarter_tab_t [QuarterLen+1];

  function automatic quarter_tab_t build_quarter_tab();
    quarter_tab_t tab;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    longint       sum;
    longint       v;
    for (int k = 0; k <= int'(QuarterLen); k++) begin
      x    = (64'(k) * HalfPiQ30 + 64'(QuarterLen / 2)) >> QuarterBits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= int'(TaylorTerms); n++) begin
        term = ((term * x2) >> 30) / TaylorDiv[n-1];
        if (n[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (sum + 64'sd16384) >>> 15;
      if (v > 32767) begin
        v = 32767;
      end
      tab[k] = TabValBits'(v);
    end
    return tab;
  endfunction

  localparam quarter_tab_t QuarterTab = build_quarter_tab();

endpackage

>>> hw/rtl/dtmf_tone_generator_top.sv
// ----------------------------------------------------------------------------
// DTMF tone generator
// Load words arm a row/column tone pair; each tick word yields one sample
// from two phase accumulators, two sine table lookups and the mixer.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake               | Word
//  --------+-------------------------+-------------------------------------
//  in      | in_valid_i / in_stall_o | in_word_i  (opcode, digit_code)
//  out     | out_valid_o / out_stall_i | out_word_o (sample, active, last)
//  cfg     | cfg_valid_i / cfg_ready_o | cfg_data_i (tone_samples)
//
// One word is taken per cycle while the input is not stalled. A tick's sample
// appears at a single output register in the cycle after the tick is accepted;
// a load produces nothing. The input stalls only while a held sample is itself
// stalled downstream. Reset clears the tone state and sets tone_samples to
// 4410; the configuration port is always ready.
module dtmf_tone_generator_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dtmf_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dtmf_pkg::out_word_t  out_word_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [dtmf_pkg::ToneLenBits-1:0] cfg_data_i
);

  logic [dtmf_pkg::ToneLenBits-1:0] tone_samples_q;
  logic [dtmf_pkg::ToneLenBits-1:0] samples_left_q, samples_left_d;
  logic [dtmf_pkg::PhaseBits-1:0]   row_step_q, row_step_d;
  logic [dtmf_pkg::PhaseBits-1:0]   col_step_q, col_step_d;
  logic [dtmf_pkg::PhaseBits-1:0]   row_phase_q, row_phase_d;
  logic [dtmf_pkg::PhaseBits-1:0]   col_phase_q, col_phase_d;
  logic                             out_valid_q, out_valid_d;
  dtmf_pkg::out_word_t              out_word_q, out_word_d;

  dtmf_pkg::key_t                        key;
  logic signed [dtmf_pkg::SampleBits-1:0] row_sine;
  logic signed [dtmf_pkg::SampleBits-1:0] col_sine;
  logic signed [dtmf_pkg::SampleBits-1:0] mixed;
  logic                                  in_fire;
  logic                                  active;

  // Handshakes.
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_fire     = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign active      = (samples_left_q != '0);

  dtmf_keypad_dec u_keypad (
    .digit_code_i (in_word_i.digit_code),
    .key_o        (key)
  );

  dtmf_sine_lut u_row_sine (
    .phase_i (row_phase_q),
    .sine_o  (row_sine)
  );

  dtmf_sine_lut u_col_sine (
    .phase_i (col_phase_q),
    .sine_o  (col_sine)
  );

  dtmf_mixer u_mixer (
    .row_sine_i (row_sine),
    .col_sine_i (col_sine),
    .sample_o   (mixed)
  );

  // Tone state: a valid key re-arms the tone when tone_samples is nonzero, a tick advances an active tone.
  always_comb begin
    samples_left_d = samples_left_q;
    row_step_d     = row_step_q;
    col_step_d     = col_step_q;
    row_phase_d    = row_phase_q;
    col_phase_d    = col_phase_q;
    if (in_fire) begin
      case (in_word_i.opcode)
        dtmf_pkg::OpLoad: begin
          if (key.hit && (tone_samples_q != '0)) begin
            row_step_d     = dtmf_pkg::RowStep[key.row];
            col_step_d     = dtmf_pkg::ColStep[key.col];
            row_phase_d    = '0;
            col_phase_d    = '0;
            samples_left_d = tone_samples_q;
          end
        end
        dtmf_pkg::OpTick: begin
          if (active) begin
            samples_left_d = samples_left_q - 1'b1;
            row_phase_d    = row_phase_q + row_step_q;
            col_phase_d    = col_phase_q + col_step_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: loaded by a tick, emptied when the word is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (in_fire && (in_word_i.opcode == dtmf_pkg::OpTick)) begin
      out_valid_d            = 1'b1;
      out_word_d.sample      = active ? mixed : '0;
      out_word_d.tone_active = active;
      out_word_d.last_sample = (samples_left_q == dtmf_pkg::ToneLenBits'(1));
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and tone registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_samples_q <= dtmf_pkg::ToneSamplesReset;
      samples_left_q <= '0;
      row_step_q     <= '0;
      col_step_q     <= '0;
      row_phase_q    <= '0;
      col_phase_q    <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        tone_samples_q <= cfg_data_i;
      end
      samples_left_q <= samples_left_d;
      row_step_q     <= row_step_d;
      col_step_q     <= col_step_d;
      row_phase_q    <= row_phase_d;
      col_phase_q    <= col_phase_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Output word payload.
  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

endmodule

>>> hw/rtl/dtmf_keypad_dec.sv
// ----------------------------------------------------------------------------
// DTMF keypad decoder
// Maps an ASCII keypad character onto its row and column tone indices.
// ----------------------------------------------------------------------------
module dtmf_keypad_dec (
  input  logic [7:0]    digit_code_i,
  output dtmf_pkg::key_t key_o
);

  // Standard 4 x 3 keypad layout; anything else is not a key.
  always_comb begin
    key_o = '{hit: 1'b1, row: 2'd0, col: 2'd0};
    case (digit_code_i)
      dtmf_pkg::CharOne:   begin key_o.row = 2'd0; key_o.col = 2'd0; end
      dtmf_pkg::CharTwo:   begin key_o.row = 2'd0; key_o.col = 2'd1; end
      dtmf_pkg::CharThree: begin key_o.row = 2'd0; key_o.col = 2'd2; end
      dtmf_pkg::CharFour:  begin key_o.row = 2'd1; key_o.col = 2'd0; end
      dtmf_pkg::CharFive:  begin key_o.row = 2'd1; key_o.col = 2'd1; end
      dtmf_pkg::CharSix:   begin key_o.row = 2'd1; key_o.col = 2'd2; end
      dtmf_pkg::CharSeven: begin key_o.row = 2'd2; key_o.col = 2'd0; end
      dtmf_pkg::CharEight: begin key_o.row = 2'd2; key_o.col = 2'd1; end
      dtmf_pkg::CharNine:  begin key_o.row = 2'd2; key_o.col = 2'd2; end
      dtmf_pkg::CharStar:  begin key_o.row = 2'd3; key_o.col = 2'd0; end
      dtmf_pkg::CharZero:  begin key_o.row = 2'd3; key_o.col = 2'd1; end
      dtmf_pkg::CharHash:  begin key_o.row = 2'd3; key_o.col = 2'd2; end
      default: begin
        key_o.hit = 1'b0;
      end
    endcase
  end

endmodule

>>> hw/rtl/dtmf_sine_lut.sv
// ----------------------------------------------------------------------------
// DTMF sine lookup
// Turns a phase accumulator value into a Q15 sine sample using the
// quarter-wave table and its symmetries.
// ----------------------------------------------------------------------------
module dtmf_sine_lut (
  input  logic [dtmf_pkg::PhaseBits-1:0]         phase_i,
  output logic signed [dtmf_pkg::SampleBits-1:0] sine_o
);

  logic [dtmf_pkg::SineTableBits-1:0] idx;
  logic [1:0]                         quad;
  logic [dtmf_pkg::QuarterBits-1:0]   pos;
  logic [dtmf_pkg::QuarterBits:0]     tab_idx;
  logic [dtmf_pkg::TabValBits-1:0]    mag;

  assign idx  = phase_i[dtmf_pkg::PhaseBits-1 -: dtmf_pkg::SineTableBits];
  assign quad = idx[dtmf_pkg::SineTableBits-1 -: 2];
  assign pos  = idx[dtmf_pkg::QuarterBits-1:0];

  // Odd quadrants read the table backwards, the lower half wave is negated.
  always_comb begin
    if (quad[0]) begin
      tab_idx = (dtmf_pkg::QuarterBits+1)'(dtmf_pkg::QuarterLen) - {1'b0, pos};
    end else begin
      tab_idx = {1'b0, pos};
    end
    mag = dtmf_pkg::QuarterTab[tab_idx];
    if (quad[1]) begin
      sine_o = -$signed({1'b0, mag});
    end else begin
      sine_o = $signed({1'b0, mag});
    end
  end

endmodule

>>> hw/rtl/dtmf_mixer.sv
// ----------------------------------------------------------------------------
// DTMF mixer
// Adds the row and column sines and scales the sum by half of 32760 in Q15,
// truncating toward zero.
// ----------------------------------------------------------------------------
module dtmf_mixer (
  input  logic signed [dtmf_pkg::SampleBits-1:0] row_sine_i,
  input  logic signed [dtmf_pkg::SampleBits-1:0] col_sine_i,
  output logic signed [dtmf_pkg::SampleBits-1:0] sample_o
);

  localparam int unsigned SumBits  = dtmf_pkg::SampleBits + 1;
  localparam int unsigned ProdBits = SumBits + dtmf_pkg::MixGainBits;

  logic signed [SumBits-1:0]         total;
  logic [SumBits-1:0]                mag;
  logic [ProdBits-1:0]               prod;
  logic [dtmf_pkg::SampleBits-1:0]   scaled;

  // Scale the magnitude so that the truncation goes toward zero.
  always_comb begin
    total  = SumBits'(row_sine_i) + SumBits'(col_sine_i);
    mag    = total[SumBits-1] ? SumBits'(-total) : SumBits'(total);
    prod   = ProdBits'(mag) * ProdBits'(dtmf_pkg::MixGain);
    scaled = prod[dtmf_pkg::MixShift +: dtmf_pkg::SampleBits];
    if (total[SumBits-1]) begin
      sample_o = -$signed(scaled);
    end else begin
      sample_o = $signed(scaled);
    end
  end

endmodule

>>> bench/dtmf_tone_generator_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DTMF tone generator checker
// Watches the input, output and configuration channels of the tone generator.
// It keeps its own model of the tone state and its own copy of tone_samples,
// predicts the sample word for every accepted tick, and compares each
// accepted output word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module dtmf_tone_generator_checker
  import dtmf_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  in_word_t               in_word_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  out_word_t              out_word_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [ToneLenBits-1:0] cfg_data_i,
  output int unsigned            mismatch_count_o,
  output int unsigned            pending_o
);

  localparam logic [15:0] ResetToneLen = 16'd4410;

  // Model state.
  logic [15:0] tone_len;
  logic [31:0] row_inc;
  logic [31:0] col_inc;
  logic [31:0] row_acc;
  logic [31:0] col_acc;
  logic [15:0] remaining;
  logic [14:0] quarter_sine [257];
  out_word_t   sample_queue [$];
  out_word_t   got_word;
  out_word_t   want_word;
  int unsigned mismatches;
  int unsigned pending;

  assign mismatch_count_o = mismatches;
  assign pending_o        = pending;

  // Quarter-wave sine in Q15 from a thirteen-term Taylor series in Q30.
  initial begin
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      acc;
    longint      v;
    for (int k = 0; k <= 256; k++) begin
      x    = (64'(k) * 64'd1686629713 + 64'd128) / 64'd256;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 12; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      v = (acc + 16384) >>> 15;
      if (v > 32767) begin
        v = 32767;
      end
      quarter_sine[k] = v[14:0];
    end
  end

  // Keypad frequencies in Hz: rows 697..941, columns 1209..1477.
  function automatic int unsigned tone_hz(bit is_col, int idx);
    if (is_col) begin
      case (idx)
        0:       return 1209;
        1:       return 1336;
        default: return 1477;
      endcase
    end
    case (idx)
      0:       return 697;
      1:       return 770;
      2:       return 852;
      default: return 941;
    endcase
  endfunction

  // Phase increment per 44.1 kHz sample, rounded with ties upwards.
  function automatic logic [31:0] phase_step(int unsigned freq);
    logic [63:0] num;
    num = (64'(freq) << 32) + 64'd22050;
    return 32'(num / 64'd44100);
  endfunction

  // Signed table value addressed by the top ten bits of a phase.
  function automatic int sine_of(logic [31:0] ph);
    logic [9:0] idx;
    int         v;
    idx = ph[31:22];
    if (idx[8]) begin
      v = int'(quarter_sine[256 - int'(idx[7:0])]);
    end else begin
      v = int'(quarter_sine[idx[7:0]]);
    end
    return idx[9] ? -v : v;
  endfunction

  // A keypad character arms a fresh tone when tone_len is nonzero; anything else leaves all as it is.
  task automatic apply_load(logic [7:0] code);
    int row;
    int col;
    row = -1;
    col = -1;
    if (code >= CharOne && code <= CharNine) begin
      row = (int'(code) - int'(CharOne)) / 3;
      col = (int'(code) - int'(CharOne)) % 3;
    end else if (code == CharStar) begin
      row = 3;
      col = 0;
    end else if (code == CharZero) begin
      row = 3;
      col = 1;
    end else if (code == CharHash) begin
      row = 3;
      col = 2;
    end
    if (row >= 0 && tone_len != 16'd0) begin
      row_inc   = phase_step(tone_hz(1'b0, row));
      col_inc   = phase_step(tone_hz(1'b1, col));
      row_acc   = '0;
      col_acc   = '0;
      remaining = tone_len;
    end
  endtask

  // One tick: the mixed sample of both sines, or a zero word when idle.
  task automatic synth_tick();
    out_word_t w;
    int        total;
    int        mag;
    int        scaled;
    int        s;
    w = '0;
    if (remaining != 16'd0) begin
      total         = sine_of(row_acc) + sine_of(col_acc);
      mag           = (total < 0) ? -total : total;
      scaled        = (mag * 16380) >>> 15;
      s             = (total < 0) ? -scaled : scaled;
      w.sample      = 16'(s);
      w.tone_active = 1'b1;
      w.last_sample = (remaining == 16'd1);
      remaining     = remaining - 16'd1;
      row_acc       = row_acc + row_inc;
      col_acc       = col_acc + col_inc;
    end
    sample_queue.push_back(w);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Compare first, then predict: a word leaving now always belongs to an
  // earlier tick.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_len  = ResetToneLen;
      row_inc   = '0;
      col_inc   = '0;
      row_acc   = '0;
      col_acc   = '0;
      remaining = '0;
      sample_queue.delete();
      mismatches = 0;
      pending    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got_word = out_word_i;
        if (sample_queue.size() == 0) begin
          report_mismatch("output word with none expected, sample",
                          int'(got_word.sample), 0);
        end else begin
          want_word = sample_queue.pop_front();
          if (got_word.sample !== want_word.sample) begin
            report_mismatch("sample", int'(got_word.sample), int'(want_word.sample));
          end
          if (got_word.tone_active !== want_word.tone_active) begin
            report_mismatch("tone_active", int'(got_word.tone_active),
                            int'(want_word.tone_active));
          end
          if (got_word.last_sample !== want_word.last_sample) begin
            report_mismatch("last_sample", int'(got_word.last_sample),
                            int'(want_word.last_sample));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_word_i.opcode == OpTick) begin
          synth_tick();
        end else begin
          apply_load(in_word_i.digit_code);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        tone_len = cfg_data_i;
      end
      pending = sample_queue.size();
    end
  end

endmodule

>>> bench/dtmf_tone_generator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DTMF tone generator testbench
// Drives load and tick words into the tone generator with random gaps and
// random output stalls, walks tone_samples through several lengths including
// zero, one and the maximum, and lets the checker predict and compare every
// sample word. A watchdog ends the run if the channels stop moving.
// ----------------------------------------------------------------------------
module dtmf_tone_generator_top_tb;
  import dtmf_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 4;
  localparam int unsigned PhaseWords    = 190;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid;
  logic                   in_stall;
  in_word_t               in_word;
  logic                   out_valid;
  logic                   out_stall;
  out_word_t              out_word;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [ToneLenBits-1:0] cfg_data;
  int unsigned            mismatch_count;
  int unsigned            pending_count;
  int unsigned            idle_cycles;
  int unsigned            calm_left;
  logic [15:0]            tone_len_now;

  dtmf_tone_generator_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  dtmf_tone_generator_checker tone_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_word_i        (in_word),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_word_i       (out_word),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  // Clock with a 12 ns period.
  initial begin
    clk_i = 1'b0;
  end

  always begin
    #6 clk_i = ~clk_i;
  end

  // Gap before a word: mostly none or short, a few long, and now and then a
  // stretch of back-to-back words.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(30, 100);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 45);
  endfunction

  function automatic logic [7:0] pick_key();
    case ($urandom_range(0, 11))
      0:       return CharZero;
      1:       return CharOne;
      2:       return CharTwo;
      3:       return CharThree;
      4:       return CharFour;
      5:       return CharFive;
      6:       return CharSix;
      7:       return CharSeven;
      8:       return CharEight;
      9:       return CharNine;
      10:      return CharStar;
      default: return CharHash;
    endcase
  endfunction

  // Number of ticks after a key: around the tone length for short tones so
  // that last samples and idle ticks both show up, bounded for long ones.
  function automatic int unsigned pick_tick_run();
    if (tone_len_now <= 16'd40) begin
      return $urandom_range(0, int'(tone_len_now) + 3);
    end
    if ($urandom_range(0, 19) == 0) begin
      return $urandom_range(100, 300);
    end
    return $urandom_range(1, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(opcode_e op, logic [7:0] code);
    int unsigned gap;
    in_word_t    w;
    gap          = pick_gap();
    w.opcode     = op;
    w.digit_code = code;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  // Tone length is only changed once every sample has come back.
  task automatic set_tone_length(logic [15:0] len);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_data  <= len;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid    <= 1'b0;
    tone_len_now = len;
  endtask

  // Mostly key presses followed by tick runs, with stray loads and loose
  // ticks mixed in. Stray characters are not counted.
  task automatic run_phase(int unsigned words);
    int unsigned sent;
    int unsigned ticks;
    int unsigned r;
    sent = 0;
    while (sent < words) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        send_word(OpLoad, pick_key());
        sent++;
        ticks = pick_tick_run();
        repeat (ticks) begin
          if ($urandom_range(0, 19) == 0) begin
            send_word(OpLoad, 8'($urandom));
          end
          send_word(OpTick, 8'($urandom));
          sent++;
        end
      end else if (r < 90) begin
        send_word(OpLoad, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_word(OpTick, 8'($urandom));
          sent++;
        end
      end
    end
  endtask

  // Output stalls: free-running stretches, and stalls of random length.
  initial begin
    int unsigned n;
    out_stall = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 99) < 20) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 150)) @(negedge clk_i);
      end else begin
        n = $urandom_range(0, 99);
        if (n < 50) n = $urandom_range(1, 3);
        else if (n < 95) n = $urandom_range(4, 10);
        else n = $urandom_range(20, 50);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
  end

  // Watchdog on cycles in which no channel moves a word.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("dtmf_tone_generator_top_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and verdict.
  initial begin
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_word      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    calm_left    = 0;
    tone_len_now = 16'd4410;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: idle tick, unknown characters, a tone interrupted by a
    // stray load, restarts on the keys 1, #, *, 0 and 9, extremes of the digit code.
    send_word(OpTick, 8'h00);
    send_word(OpLoad, 8'h00);
    send_word(OpTick, 8'hFF);
    send_word(OpLoad, CharOne);
    send_word(OpTick, 8'h00);
    send_word(OpTick, 8'h55);
    send_word(OpTick, 8'hAA);
    send_word(OpLoad, 8'hFF);
    send_word(OpTick, 8'h00);
    send_word(OpLoad, CharHash);
    send_word(OpTick, 8'h00);
    send_word(OpTick, 8'h00);
    send_word(OpLoad, CharStar);
    send_word(OpTick, 8'h00);
    send_word(OpLoad, CharZero);
    send_word(OpTick, 8'h00);
    send_word(OpLoad, CharNine);
    send_word(OpTick, 8'h00);
    send_word(OpLoad, 8'h2F);
    send_word(OpLoad, 8'h3A);
    send_word(OpTick, 8'h00);

    // Random phases over a spread of tone lengths.
    set_tone_length(16'd1);
    run_phase(PhaseWords);
    set_tone_length(16'd2);
    run_phase(PhaseWords);
    set_tone_length(16'd3);
    run_phase(PhaseWords);
    set_tone_length(16'($urandom_range(4, 12)));
    run_phase(PhaseWords);
    set_tone_length(16'd0);
    run_phase(PhaseWords);
    set_tone_length(16'd65535);
    run_phase(PhaseWords);
    set_tone_length(16'($urandom_range(13, 40)));
    run_phase(PhaseWords);
    set_tone_length(16'd4410);
    run_phase(PhaseWords);

    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("dtmf_tone_generator_top_tb: PASS");
    end else begin
      $display("dtmf_tone_generator_top_tb: FAIL");
    end
    $finish;
  end

endmodule
